// ----- rtl/tpt_pkg.sv -----
// Shared types and constants of the trajectory point tracker.
`timescale 1ns / 1ps
package tpt_pkg;
    localparam int MaxPointsDef = 256;
    localparam int unsigned Len2Min = 4295;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_START  = 2'd1,
        MODE_UPDATE = 2'd2,
        MODE_ABORT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_FINISH  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_EARLY   = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_TRACK, S_DIV_RD, S_SEG_A, S_SEG_B,
        S_SEG_C, S_DIV, S_POS, S_LERP_RD, S_LERP_A, S_LERP_B, S_LERP_C,
        S_LAST_RD, S_LAST, S_DONE, S_TDIV
    } t_state;
endpackage

// ----- rtl/tpt_path_mem.sv -----
// Path store: four words per point in one synchronous memory.
`timescale 1ns / 1ps
module tpt_path_mem #(
    parameter int MAX_POINTS = tpt_pkg::MaxPointsDef,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_addr,
    input  logic [127:0]         i_wdata,
    output logic [127:0]         o_rdata
);
    import tpt_pkg::*;
    logic [127:0] r_mem [MAX_POINTS];

    // Read first: a read in the cycle of a write returns the old word; the read is registered.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/trajectory_point_tracker.sv -----
// Top level of the trajectory point tracker: sequencer, arithmetic and registers.
//   channel | direction | handshake
//   request | in        | i_valid / o_stall
//   result  | out       | o_valid / i_stall
//   config  | in        | i_cfg_we (no handshake)
// A load, start or abort passes from the idle state to the done state, which raises its result.
// An update scans the stored points through the path memory, one point a cycle,
// then picks the target, divides elapsed by timeout when the stall timeout forces
// the target forward, and runs the 16-step division when the segment fraction
// needs it. A single-point run goes straight to reading the last point.
// Reset is synchronous; the path memory is not cleared.
// A result waits in its register while i_stall is high; no new request is taken meanwhile.
`timescale 1ns / 1ps
module trajectory_point_tracker #(
    parameter int MAX_POINTS = tpt_pkg::MaxPointsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_point_index,
    input  logic [8:0]         i_point_count,
    input  logic signed [31:0] i_point_base,
    input  logic signed [31:0] i_point_joint,
    input  logic signed [31:0] i_point_base_vel,
    input  logic signed [31:0] i_point_joint_vel,
    input  logic signed [31:0] i_measured_base,
    input  logic signed [31:0] i_measured_joint,
    input  logic [31:0]        i_now_tick,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic               o_running,
    output logic [7:0]         o_target_point,
    output logic signed [31:0] o_cmd_base_pos,
    output logic signed [31:0] o_cmd_joint_pos,
    output logic signed [31:0] o_cmd_base_vel,
    output logic signed [31:0] o_cmd_joint_vel
);
    import tpt_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    // Configuration registers.
    logic [22:0] r_finish;
    logic [15:0] r_timeout;
    logic [3:0]  r_early;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finish  <= 23'd65536;
            r_timeout <= 16'd1000;
            r_early   <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FINISH:  r_finish  <= i_cfg_data;
                CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                CFG_EARLY:   r_early   <= i_cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Architectural state.
    t_state      r_state, n_state;
    logic [CW-1:0] r_count;
    logic        r_run;
    logic [AW-1:0] r_last_tgt, r_cur;
    logic [31:0] r_stall_tick;
    logic signed [31:0] r_cmd [4];
    // Per-request work registers.
    logic [1:0]  r_mode;
    logic [7:0]  r_pidx;
    logic [8:0]  r_pcnt;
    logic [127:0] r_pt;
    logic signed [31:0] r_mb, r_mj;
    logic [31:0] r_now;
    logic        r_busy;
    logic [CW-1:0] r_i;
    logic [65:0] r_best;
    logic [AW-1:0] r_best_i, r_tgt;
    logic signed [31:0] r_a0, r_a1, r_a2, r_a3;
    logic signed [32:0] r_ab, r_aj, r_mbd, r_mjd;
    logic [65:0] r_len2, r_dot, r_rem;
    logic [16:0] r_t;
    logic [4:0]  r_k;
    logic [CW+16:0] r_pos;
    logic signed [63:0] r_p0, r_p1;
    logic [31:0] r_el, r_q, r_rm;
    logic        r_ok;
    logic        r_ov;

    // Memory port.
    logic         mem_we;
    logic [AW-1:0] mem_addr;
    logic [127:0] mem_rd;
    tpt_path_mem #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(r_pt), .o_rdata(mem_rd)
    );

    logic signed [31:0] rd_b, rd_j, rd_bv, rd_jv;
    assign rd_b  = mem_rd[127:96];
    assign rd_j  = mem_rd[95:64];
    assign rd_bv = mem_rd[63:32];
    assign rd_jv = mem_rd[31:0];

    logic [AW-1:0] last;
    assign last = AW'(r_count - CW'(1));
    logic accept;
    assign accept = i_valid && !o_stall;
    assign o_stall = r_busy || (o_valid && i_stall);

    // The tracked point moves one past the target, never beyond the last point.
    logic [AW-1:0] tgt_next;
    assign tgt_next = (r_tgt == last) ? last : r_tgt + AW'(1);

    // The segment fraction is known without dividing.
    logic div_skip;
    assign div_skip = r_tgt >= last || r_len2 < 66'(Len2Min) || r_dot[65] || r_dot == 0
                      || r_dot >= r_len2;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (r_busy) n_state = (r_mode == MODE_UPDATE && r_count != 0
                           && r_run && r_count != CW'(1)) ? S_SCAN_RD
                           : (r_mode == MODE_UPDATE && r_count == CW'(1) && r_run)
                           ? S_LAST_RD : S_DONE;
            S_SCAN_RD: n_state = S_SCAN;
            S_SCAN:    if (r_i == r_count) n_state = S_TRACK;
            S_TRACK:   n_state = S_TDIV;
            S_TDIV:    if (r_k == 5'd0 || !r_ov) n_state = S_DIV_RD;
            S_DIV_RD:  n_state = S_SEG_A;
            S_SEG_A:   n_state = S_SEG_B;
            S_SEG_B:   n_state = S_SEG_C;
            S_SEG_C:   n_state = S_DIV;
            S_DIV:     if (r_k == 5'd0 || (r_k == 5'd16 && div_skip)) n_state = S_POS;
            S_POS:     n_state = S_LERP_RD;
            S_LERP_RD: n_state = S_LERP_A;
            S_LERP_A:  n_state = S_LERP_B;
            S_LERP_B:  n_state = S_LERP_C;
            S_LERP_C:  n_state = S_LAST_RD;
            S_LAST_RD: n_state = S_LAST;
            S_LAST:    n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory address and write enable.
    always_comb begin
        mem_we = 1'b0;
        mem_addr = r_tgt;
        unique case (r_state)
            S_IDLE: begin
                mem_we = r_busy && r_mode == MODE_LOAD && !r_run
                         && {1'b0, r_pidx} < 9'(MAX_POINTS);
                mem_addr = AW'(r_pidx);
            end
            S_SCAN_RD, S_SCAN: mem_addr = r_i[AW-1:0];
            S_DIV_RD:  mem_addr = tgt_next;
            S_SEG_A:   mem_addr = r_tgt + AW'(1);
            S_LERP_RD: mem_addr = AW'(r_pos >> 16);
            S_LERP_A:  mem_addr = AW'(r_pos >> 16) + AW'(1);
            S_LAST_RD: mem_addr = last;
            default:   mem_addr = r_tgt;
        endcase
    end

    // Arithmetic helpers.
    logic signed [32:0] db, dj;
    logic [65:0] d2;
    assign db = 33'(rd_b) - 33'(r_mb);
    assign dj = 33'(rd_j) - 33'(r_mj);
    assign d2 = 66'(db * db) + 66'(dj * dj);
    logic [15:0] tmo;
    assign tmo = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    logic [66:0] rsh;
    assign rsh = {r_rem, 1'b0};
    logic [32:0] tr;
    assign tr = {r_rm, r_el[31]};
    logic [16:0] frac;
    assign frac = r_pos[16:0] & 17'h0FFFF;
    function automatic logic signed [31:0] lerp_fix(
        input logic signed [31:0] a, input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> 16;
        return 32'(64'(a) + q);
    endfunction
    logic signed [32:0] eb, ej;
    logic [32:0] aeb, aej;
    assign eb = 33'(rd_b) - 33'(r_mb);
    assign ej = 33'(rd_j) - 33'(r_mj);
    assign aeb = eb[32] ? 33'(-eb) : 33'(eb);
    assign aej = ej[32] ? 33'(-ej) : 33'(ej);

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
            r_count <= '0;
            r_run   <= 1'b0;
            r_last_tgt <= '0;
            r_cur   <= '0;
            r_stall_tick <= '0;
            for (int n = 0; n < 4; n++) r_cmd[n] <= '0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall) o_valid <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_mode <= i_mode; r_pidx <= i_point_index; r_pcnt <= i_point_count;
                r_pt <= {i_point_base, i_point_joint, i_point_base_vel,
                         i_point_joint_vel};
                r_mb <= i_measured_base; r_mj <= i_measured_joint;
                r_now <= i_now_tick;
            end
            unique case (r_state)
                S_IDLE: if (r_busy) begin
                    r_i <= '0;
                    unique case (t_mode'(r_mode))
                        MODE_LOAD: r_ok <= !r_run && {1'b0, r_pidx} < 9'(MAX_POINTS);
                        MODE_START:
                            if (!r_run && r_pcnt != 0 && 32'(r_pcnt) <= MAX_POINTS) begin
                                r_count <= CW'(r_pcnt);
                                r_cur <= '0; r_last_tgt <= '0;
                                r_stall_tick <= r_now; r_run <= 1'b1;
                                r_ok <= 1'b1;
                            end else r_ok <= 1'b0;
                        MODE_UPDATE: r_ok <= r_count != 0;
                        MODE_ABORT: begin
                            r_run <= 1'b0; r_count <= '0; r_cur <= '0;
                            r_last_tgt <= '0; r_stall_tick <= '0;
                            r_cmd[2] <= '0; r_cmd[3] <= '0;
                            r_ok <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_SCAN_RD: r_i <= r_i + CW'(1);
                S_SCAN: begin
                    if (r_i == CW'(1) || d2 < r_best) begin
                        r_best <= d2; r_best_i <= AW'(r_i - CW'(1));
                    end
                    if (r_i != r_count) r_i <= r_i + CW'(1);
                end
                S_TRACK: begin
                    r_tgt <= (r_best_i < r_last_tgt) ? r_last_tgt : r_best_i;
                    r_el <= r_now - r_stall_tick;
                    r_rm <= '0; r_q <= '0; r_k <= 5'd31;
                    r_ov <= (r_best_i <= r_last_tgt) && (r_now - r_stall_tick)
                            >= 32'(tmo) && ((r_best_i < r_last_tgt) ? r_last_tgt
                            : r_best_i) < last;
                    if (r_best_i > r_last_tgt) begin
                        r_stall_tick <= r_now; r_last_tgt <= r_best_i;
                    end
                end
                S_TDIV: if (r_ov) begin
                    // One quotient bit a cycle of elapsed / timeout.
                    if (tr >= 33'(tmo)) begin
                        r_rm <= 32'(tr - 33'(tmo)); r_q <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rm <= tr[31:0]; r_q <= {r_q[30:0], 1'b0};
                    end
                    r_el <= {r_el[30:0], 1'b0};
                    if (r_k != 5'd0) r_k <= r_k - 5'd1;
                    else begin
                        logic [31:0] qf, room, ex;
                        qf = tr >= 33'(tmo) ? {r_q[30:0], 1'b1} : {r_q[30:0], 1'b0};
                        room = 32'(last - r_tgt);
                        ex = (qf > room) ? room : qf;
                        r_tgt <= r_tgt + AW'(ex);
                        r_stall_tick <= r_stall_tick + ex * 32'(tmo);
                    end
                end
                S_DIV_RD: r_tgt <= tgt_next;
                S_SEG_A: begin
                    r_a0 <= rd_b; r_a1 <= rd_j;
                end
                S_SEG_B: begin
                    r_ab <= 33'(rd_b) - 33'(r_a0);
                    r_aj <= 33'(rd_j) - 33'(r_a1);
                    r_mbd <= 33'(r_mb) - 33'(r_a0);
                    r_mjd <= 33'(r_mj) - 33'(r_a1);
                end
                S_SEG_C: begin
                    r_len2 <= 66'(r_ab * r_ab) + 66'(r_aj * r_aj);
                    r_dot  <= 66'(r_mbd * r_ab) + 66'(r_mjd * r_aj);
                    r_rem  <= 66'(r_mbd * r_ab) + 66'(r_mjd * r_aj);
                    r_t <= '0; r_k <= 5'd16;
                end
                S_DIV: begin
                    if (r_k == 5'd16) begin
                        if (r_tgt >= last || r_len2 < 66'(Len2Min) || r_dot[65]
                            || r_dot == 0) begin r_t <= '0; r_k <= 5'd0; end
                        else if (r_dot >= r_len2) begin r_t <= 17'h10000; r_k <= 5'd0; end
                        else r_k <= r_k - 5'd1;
                    end else begin
                        if (67'(rsh) >= 67'(r_len2)) begin
                            r_rem <= 66'(rsh - 67'(r_len2)); r_t <= {r_t[15:0], 1'b1};
                        end else begin
                            r_rem <= rsh[65:0]; r_t <= {r_t[15:0], 1'b0};
                        end
                        if (r_k != 5'd0) r_k <= r_k - 5'd1;
                    end
                end
                S_POS: begin
                    logic [CW+16:0] p, lim;
                    p = ({(CW+1)'(r_tgt) + (CW+1)'(1), 16'd0}) + (CW+17)'(r_t);
                    lim = {(CW+1)'(last), 16'd0};
                    r_pos <= (p > lim) ? lim : p;
                    r_cur <= r_tgt;
                end
                S_LERP_A: begin
                    r_a0 <= rd_b; r_a1 <= rd_j; r_a2 <= rd_bv; r_a3 <= rd_jv;
                end
                S_LERP_B: begin
                    r_p0 <= 64'($signed({1'b0, frac})) * 64'(33'(rd_b) - 33'(r_a0));
                    r_p1 <= 64'($signed({1'b0, frac})) * 64'(33'(rd_j) - 33'(r_a1));
                    r_ab <= 33'(rd_bv) - 33'(r_a2);
                    r_aj <= 33'(rd_jv) - 33'(r_a3);
                end
                S_LERP_C: begin
                    if (AW'(r_pos >> 16) >= last) ;
                    else begin
                        r_cmd[0] <= lerp_fix(r_a0, r_p0);
                        r_cmd[1] <= lerp_fix(r_a1, r_p1);
                        r_cmd[2] <= lerp_fix(r_a2, 64'($signed({1'b0, frac})) * 64'(r_ab));
                        r_cmd[3] <= lerp_fix(r_a3, 64'($signed({1'b0, frac})) * 64'(r_aj));
                    end
                end
                S_LAST: begin
                    if (r_count == CW'(1)) begin
                        r_cmd[0] <= rd_b; r_cmd[1] <= rd_j;
                        r_cmd[2] <= '0; r_cmd[3] <= '0; r_run <= 1'b0;
                    end else if ((r_early != 0 && 32'(r_cur) + 32'(r_early) >= 32'(last))
                        || (aeb <= 33'(r_finish) && aej <= 33'(r_finish))) begin
                        r_cmd[0] <= rd_b; r_cmd[1] <= rd_j;
                        r_cmd[2] <= '0; r_cmd[3] <= '0; r_run <= 1'b0;
                    end else if (AW'(r_pos >> 16) >= last) begin
                        r_cmd[0] <= rd_b; r_cmd[1] <= rd_j;
                        r_cmd[2] <= rd_bv; r_cmd[3] <= rd_jv;
                    end
                end
                S_DONE: begin
                    r_busy <= 1'b0; o_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Result outputs.
    assign o_ok = r_ok;
    assign o_running = r_run;
    assign o_target_point = 8'(r_cur);
    assign o_cmd_base_pos = r_cmd[0];
    assign o_cmd_joint_pos = r_cmd[1];
    assign o_cmd_base_vel = r_cmd[2];
    assign o_cmd_joint_vel = r_cmd[3];
endmodule

// ----- rtl/tpt_checker.sv -----
// Port checker for the trajectory point tracker, bound to the top level.
`timescale 1ns / 1ps
module tpt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_ok,
    input logic o_running
);
    // A held result keeps its flags.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_running))
        else $error("held result changed");
    // No request is taken while a result waits under stall.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("request taken over a stalled result");
    // A request taken makes the block busy next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken during work");
endmodule

bind trajectory_point_tracker tpt_checker u_tpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_ok(o_ok), .o_running(o_running)
);
